>>> sv/vna_pkg.sv
// Shared types and constants for the vertex normal accumulator.
// No dependencies.
package vna_pkg;

	localparam int VERTEX_COUNT_DEF = 1024;
	localparam int SUM_BITS_DEF     = 24;
	localparam int IDX_W            = 10;
	localparam int POS_W            = 16;
	localparam int OUT_W            = 24;
	localparam int DIF_W            = 17;
	localparam int CRS_W            = 35;
	localparam int UNIT_W           = 16;
	localparam int MAX_DEPTH        = 1 << IDX_W;

	typedef enum logic [1:0] {
		CMD_STORE    = 2'd0,
		CMD_TRIANGLE = 2'd1,
		CMD_READ     = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]              command;
		logic [IDX_W-1:0]        vertex_index;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [IDX_W-1:0]        corner_a;
		logic [IDX_W-1:0]        corner_b;
		logic [IDX_W-1:0]        corner_c;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] normal_x;
		logic signed [OUT_W-1:0] normal_y;
		logic signed [OUT_W-1:0] normal_z;
	} out_item_t;

	typedef struct packed {
		cmd_t               op;
		logic               in_range;
		logic [IDX_W-1:0]   vertex_index;
		logic [3*POS_W-1:0] pos;
		logic [IDX_W-1:0]   corner_a;
		logic [IDX_W-1:0]   corner_b;
		logic [IDX_W-1:0]   corner_c;
	} q_item_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

endpackage

>>> sv/vertex_normal_accumulator.sv
// Vertex normal accumulator: command channel in, normal-sum channel out.
// Commands: store a vertex position, add a triangle's unit face normal to its
// three corners (saturating), read one vertex's sum, clear all sums.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// A front end range-checks each command beat and queues up to two; the back end
// runs them one at a time against two RAMs (positions, normal sums).
// In the back end a store is written as it leaves the queue, a read waits
// while the output is stalled, and a triangle runs the normalize shift (one
// step per cycle), the 21-step square root and the 15-step three-lane divide,
// then three read-modify-writes of the sum RAM; a degenerate one skips the
// root and the divide. A clear command sweeps the sum RAM one entry a cycle
// over VERTEX_COUNT entries (at most 1024); cmd_stall is high during the sweep.
// After arst_n is released the same sweep runs first, so the block accepts
// no command until it ends. Positions are undefined until stored.
// A read result sits in an output register; while nrm_stall holds it, the
// back end stops at the next read but the queue still takes beats.
// Depends on vna_pkg, vna_front, vna_back.
module vertex_normal_accumulator import vna_pkg::*; #(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
	parameter int SUM_BITS     = SUM_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  in_item_t  cmd_data,
	output logic      nrm_valid,
	input  logic      nrm_stall,
	output out_item_t nrm_data
);

	logic      q_valid;
	q_item_t   q_item;
	back_ctl_t ctl;

	vna_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.ctl       (ctl)
	);

	vna_back #(.VERTEX_COUNT(VERTEX_COUNT), .SUM_BITS(SUM_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.ctl       (ctl),
		.nrm_valid (nrm_valid),
		.nrm_stall (nrm_stall),
		.nrm_data  (nrm_data)
	);

endmodule

>>> sv/vna_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module vna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/vna_front.sv
// Front end: accepts command beats, range-checks indices, queues two entries.
// Depends on vna_pkg.
module vna_front import vna_pkg::*; #(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  in_item_t  cmd_data,
	output logic      q_valid,
	output q_item_t   q_item,
	input  back_ctl_t ctl
);

	localparam logic [16:0] LIMIT = 17'(VERTEX_COUNT);

	q_item_t    item_d;
	q_item_t    slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;

	function automatic logic idx_ok(input logic [IDX_W-1:0] i);
		return 17'(i) < LIMIT;
	endfunction

	always_comb begin
		item_d.op           = cmd_t'(cmd_data.command);
		item_d.vertex_index = cmd_data.vertex_index;
		item_d.pos          = {cmd_data.pos_x, cmd_data.pos_y, cmd_data.pos_z};
		item_d.corner_a     = cmd_data.corner_a;
		item_d.corner_b     = cmd_data.corner_b;
		item_d.corner_c     = cmd_data.corner_c;
		case (item_d.op)
			CMD_STORE, CMD_READ: item_d.in_range = idx_ok(cmd_data.vertex_index);
			CMD_TRIANGLE: item_d.in_range = idx_ok(cmd_data.corner_a) &&
				idx_ok(cmd_data.corner_b) && idx_ok(cmd_data.corner_c);
			default: item_d.in_range = 1'b1;
		endcase
	end

	assign cmd_stall = (cnt_q == 2'd2) || ctl.clearing;
	assign push      = cmd_valid && !cmd_stall;
	assign q_valid   = cnt_q != 2'd0;
	assign q_item    = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (ctl.pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !ctl.pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && ctl.pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= item_d;
		end
	end

endmodule

>>> sv/vna_norm.sv
// Unit-vector unit: scales a cross product to a Q1.14 unit vector using an
// iterative shift, squares, bitwise square root and three-lane division.
// Depends on vna_pkg.
module vna_norm import vna_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [CRS_W-1:0]  cx,
	input  logic signed [CRS_W-1:0]  cy,
	input  logic signed [CRS_W-1:0]  cz,
	output logic                     done,
	output logic signed [UNIT_W-1:0] ux,
	output logic signed [UNIT_W-1:0] uy,
	output logic signed [UNIT_W-1:0] uz
);

	localparam int SQ_W  = 42;
	localparam int R_W   = 21;
	localparam int Q_W   = 15;
	localparam int A_W   = 20;

	typedef enum logic [6:0] {
		N_IDLE  = 7'b0000001,
		N_SHIFT = 7'b0000010,
		N_SQ    = 7'b0000100,
		N_SQRT  = 7'b0001000,
		N_DINIT = 7'b0010000,
		N_DIV   = 7'b0100000,
		N_DONE  = 7'b1000000
	} nstate_t;

	nstate_t            state_q;
	logic [3:0]         cnt_q;
	logic [CRS_W-1:0]   mag_q [3];
	logic               neg_q [3];
	logic [CRS_W-1:0]   m;
	logic [A_W-1:0]     sq_op;
	logic [2*A_W-1:0]   prod_q;
	logic [SQ_W-1:0]    s_q;
	logic [SQ_W-1:0]    res_q;
	logic [SQ_W-1:0]    bit_q;
	logic [SQ_W:0]      trial;
	logic [R_W-1:0]     r;
	logic [R_W-1:0]     rem_q [3];
	logic [Q_W-1:0]     nlo_q [3];
	logic [Q_W-1:0]     quo_q [3];
	logic [CRS_W-1:0]   nfull [3];
	logic [R_W:0]       dtmp  [3];
	logic               dge   [3];

	always_comb begin
		m = mag_q[0];
		if (mag_q[1] > m) begin
			m = mag_q[1];
		end
		if (mag_q[2] > m) begin
			m = mag_q[2];
		end
	end

	always_comb begin
		case (cnt_q)
			4'd0: sq_op = mag_q[0][A_W-1:0];
			4'd1: sq_op = mag_q[1][A_W-1:0];
			4'd2: sq_op = mag_q[2][A_W-1:0];
			default: sq_op = '0;
		endcase
	end

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign r     = res_q[R_W-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nfull[i] = CRS_W'({mag_q[i][A_W-1:0], 14'd0}) + CRS_W'(r[R_W-1:1]);
			dtmp[i]  = {rem_q[i], nlo_q[i][Q_W-1]};
			dge[i]   = dtmp[i] >= {1'b0, r};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				N_IDLE: if (start) begin
					state_q <= N_SHIFT;
				end
				N_SHIFT: begin
					cnt_q <= '0;
					if (m == '0) begin
						state_q <= N_DONE;
					end else if (m[CRS_W-1:A_W] == '0 && m[A_W-1]) begin
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd3) begin
						state_q <= N_SQRT;
					end
				end
				N_SQRT: if (bit_q[0]) begin
					state_q <= N_DINIT;
				end
				N_DINIT: begin
					cnt_q   <= '0;
					state_q <= N_DIV;
				end
				N_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(Q_W - 1)) begin
						state_q <= N_DONE;
					end
				end
				N_DONE: state_q <= N_IDLE;
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				mag_q[0] <= cx[CRS_W-1] ? CRS_W'(-cx) : CRS_W'(cx);
				mag_q[1] <= cy[CRS_W-1] ? CRS_W'(-cy) : CRS_W'(cy);
				mag_q[2] <= cz[CRS_W-1] ? CRS_W'(-cz) : CRS_W'(cz);
				neg_q[0] <= cx[CRS_W-1];
				neg_q[1] <= cy[CRS_W-1];
				neg_q[2] <= cz[CRS_W-1];
			end
			N_SHIFT: begin
				s_q <= '0;
				for (int i = 0; i < 3; i++) begin
					if (m[CRS_W-1:A_W] != '0) begin
						mag_q[i] <= mag_q[i] >> 1;
					end else if (!m[A_W-1] && m != '0) begin
						mag_q[i] <= mag_q[i] << 1;
					end
					quo_q[i] <= '0;
				end
			end
			N_SQ: begin
				prod_q <= sq_op * sq_op;
				if (cnt_q != 4'd0) begin
					s_q <= s_q + SQ_W'(prod_q);
				end
				res_q <= '0;
				bit_q <= SQ_W'(1) << (SQ_W - 2);
			end
			N_SQRT: begin
				if ({1'b0, s_q} >= trial) begin
					s_q   <= SQ_W'({1'b0, s_q} - trial);
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DINIT: begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= R_W'(nfull[i][CRS_W-1:Q_W]);
					nlo_q[i] <= nfull[i][Q_W-1:0];
				end
			end
			N_DIV: begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= dge[i] ? R_W'(dtmp[i] - {1'b0, r}) : dtmp[i][R_W-1:0];
					nlo_q[i] <= nlo_q[i] << 1;
					quo_q[i] <= {quo_q[i][Q_W-2:0], dge[i]};
				end
			end
			default: ;
		endcase
	end

	assign done = state_q == N_DONE;
	assign ux = neg_q[0] ? -$signed({1'b0, quo_q[0]}) : $signed({1'b0, quo_q[0]});
	assign uy = neg_q[1] ? -$signed({1'b0, quo_q[1]}) : $signed({1'b0, quo_q[1]});
	assign uz = neg_q[2] ? -$signed({1'b0, quo_q[2]}) : $signed({1'b0, quo_q[2]});

endmodule

>>> sv/vna_back.sv
// Back end: sequencer over the position and normal-sum RAMs, cross product,
// saturating accumulation, clearing sweep and output register.
// Depends on vna_pkg, vna_ram, vna_norm.
module vna_back import vna_pkg::*; #(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
	parameter int SUM_BITS     = SUM_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  q_item_t   q_item,
	output back_ctl_t ctl,
	output logic      nrm_valid,
	input  logic      nrm_stall,
	output out_item_t nrm_data
);

	localparam int DEPTH = (VERTEX_COUNT > MAX_DEPTH) ? MAX_DEPTH : VERTEX_COUNT;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = 3 * SUM_BITS;
	localparam int PW    = 3 * POS_W;
	localparam int MW    = 2 * DIF_W;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	typedef enum logic [12:0] {
		B_CLEAR  = 13'h0001,
		B_IDLE   = 13'h0002,
		B_FA     = 13'h0004,
		B_FB     = 13'h0008,
		B_FC     = 13'h0010,
		B_FD     = 13'h0020,
		B_DIFF   = 13'h0040,
		B_MUL    = 13'h0080,
		B_NORM   = 13'h0100,
		B_ACC_RD = 13'h0200,
		B_ACC_WR = 13'h0400,
		B_RD     = 13'h0800,
		B_EMIT   = 13'h1000
	} bstate_t;

	bstate_t                  state_q;
	q_item_t                  cur_q;
	logic [AW-1:0]            clr_q;
	logic [2:0]               mcnt_q;
	logic [1:0]               acnt_q;
	logic                     norm_start_q;
	logic                     nrm_valid_q;
	out_item_t                nrm_data_q;
	logic [PW-1:0]            pa_q, pb_q, pc_q;
	logic signed [DIF_W-1:0]  v1_q [3];
	logic signed [DIF_W-1:0]  v2_q [3];
	logic signed [DIF_W-1:0]  ma, mb;
	logic signed [MW-1:0]     prod_q;
	logic signed [CRS_W-1:0]  crs_q [3];

	logic                     pos_we;
	logic [AW-1:0]            pos_raddr;
	logic [PW-1:0]            pos_rdata;
	logic                     sum_we;
	logic [AW-1:0]            sum_waddr, sum_raddr;
	logic [NW-1:0]            sum_wdata, sum_rdata;
	logic [IDX_W-1:0]         acc_idx;

	logic                     norm_done;
	logic signed [UNIT_W-1:0] ux, uy, uz;
	logic signed [SUM_BITS-1:0] sx, sy, sz;

	function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] acc,
		input logic signed [UNIT_W-1:0] u);
		logic signed [SUM_BITS:0] t;
		t = $signed({acc[SUM_BITS-1], acc}) + (SUM_BITS+1)'(u);
		if (t[SUM_BITS] != t[SUM_BITS-1]) begin
			return t[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
		end
		return t[SUM_BITS-1:0];
	endfunction

	function automatic logic signed [DIF_W-1:0] pdiff(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		return $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
	endfunction

	vna_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (q_item.vertex_index[AW-1:0]),
		.wdata (q_item.pos),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	vna_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	vna_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start_q),
		.cx     (crs_q[0]),
		.cy     (crs_q[1]),
		.cz     (crs_q[2]),
		.done   (norm_done),
		.ux     (ux),
		.uy     (uy),
		.uz     (uz)
	);

	assign ctl.pop      = (state_q == B_IDLE) && q_valid;
	assign ctl.clearing = state_q == B_CLEAR;
	assign pos_we = ctl.pop && q_item.op == CMD_STORE && q_item.in_range;

	always_comb begin
		case (state_q)
			B_FB: pos_raddr = cur_q.corner_b[AW-1:0];
			B_FC: pos_raddr = cur_q.corner_c[AW-1:0];
			default: pos_raddr = cur_q.corner_a[AW-1:0];
		endcase
		case (acnt_q)
			2'd0: acc_idx = cur_q.corner_a;
			2'd1: acc_idx = cur_q.corner_b;
			default: acc_idx = cur_q.corner_c;
		endcase
		if (state_q == B_RD || state_q == B_EMIT) begin
			sum_raddr = cur_q.vertex_index[AW-1:0];
		end else begin
			sum_raddr = acc_idx[AW-1:0];
		end
		sum_wdata = {sat_add(sum_rdata[NW-1 -: SUM_BITS], ux),
			sat_add(sum_rdata[2*SUM_BITS-1 -: SUM_BITS], uy),
			sat_add(sum_rdata[SUM_BITS-1:0], uz)};
		if (state_q == B_CLEAR) begin
			sum_we    = 1'b1;
			sum_waddr = clr_q;
			sum_wdata = '0;
		end else begin
			sum_we    = state_q == B_ACC_WR;
			sum_waddr = acc_idx[AW-1:0];
		end
		case (mcnt_q)
			3'd0: begin ma = v1_q[1]; mb = v2_q[2]; end
			3'd1: begin ma = v1_q[2]; mb = v2_q[1]; end
			3'd2: begin ma = v1_q[2]; mb = v2_q[0]; end
			3'd3: begin ma = v1_q[0]; mb = v2_q[2]; end
			3'd4: begin ma = v1_q[0]; mb = v2_q[1]; end
			default: begin ma = v1_q[1]; mb = v2_q[0]; end
		endcase
	end

	assign sx = sum_rdata[NW-1 -: SUM_BITS];
	assign sy = sum_rdata[2*SUM_BITS-1 -: SUM_BITS];
	assign sz = sum_rdata[SUM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_CLEAR;
			clr_q        <= '0;
			mcnt_q       <= '0;
			acnt_q       <= '0;
			norm_start_q <= 1'b0;
			nrm_valid_q  <= 1'b0;
		end else begin
			norm_start_q <= 1'b0;
			if (nrm_valid_q && !nrm_stall) begin
				nrm_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: if (q_valid) begin
					case (q_item.op)
						CMD_TRIANGLE: if (q_item.in_range) begin
							state_q <= B_FA;
						end
						CMD_READ: state_q <= q_item.in_range ? B_RD : B_EMIT;
						CMD_CLEAR: begin
							clr_q   <= '0;
							state_q <= B_CLEAR;
						end
						default: state_q <= B_IDLE;
					endcase
				end
				B_FA: state_q <= B_FB;
				B_FB: state_q <= B_FC;
				B_FC: state_q <= B_FD;
				B_FD: state_q <= B_DIFF;
				B_DIFF: begin
					mcnt_q  <= '0;
					state_q <= B_MUL;
				end
				B_MUL: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd6) begin
						norm_start_q <= 1'b1;
						state_q      <= B_NORM;
					end
				end
				B_NORM: if (norm_done) begin
					acnt_q  <= '0;
					state_q <= B_ACC_RD;
				end
				B_ACC_RD: state_q <= B_ACC_WR;
				B_ACC_WR: begin
					acnt_q  <= acnt_q + 2'd1;
					state_q <= (acnt_q == 2'd2) ? B_IDLE : B_ACC_RD;
				end
				B_RD: state_q <= B_EMIT;
				B_EMIT: if (!nrm_valid_q || !nrm_stall) begin
					nrm_valid_q <= 1'b1;
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			cur_q <= q_item;
		end
		if (state_q == B_FB) begin
			pa_q <= pos_rdata;
		end
		if (state_q == B_FC) begin
			pb_q <= pos_rdata;
		end
		if (state_q == B_FD) begin
			pc_q <= pos_rdata;
		end
		if (state_q == B_DIFF) begin
			for (int i = 0; i < 3; i++) begin
				v1_q[i] <= pdiff(pa_q[PW-1-i*POS_W -: POS_W], pb_q[PW-1-i*POS_W -: POS_W]);
				v2_q[i] <= pdiff(pb_q[PW-1-i*POS_W -: POS_W], pc_q[PW-1-i*POS_W -: POS_W]);
			end
		end
		if (state_q == B_MUL) begin
			prod_q <= ma * mb;
			case (mcnt_q)
				3'd1: crs_q[0] <= CRS_W'(prod_q);
				3'd2: crs_q[0] <= crs_q[0] - CRS_W'(prod_q);
				3'd3: crs_q[1] <= CRS_W'(prod_q);
				3'd4: crs_q[1] <= crs_q[1] - CRS_W'(prod_q);
				3'd5: crs_q[2] <= CRS_W'(prod_q);
				3'd6: crs_q[2] <= crs_q[2] - CRS_W'(prod_q);
				default: ;
			endcase
		end
		if (state_q == B_EMIT && (!nrm_valid_q || !nrm_stall)) begin
			if (cur_q.in_range) begin
				nrm_data_q.normal_x <= OUT_W'(sx);
				nrm_data_q.normal_y <= OUT_W'(sy);
				nrm_data_q.normal_z <= OUT_W'(sz);
			end else begin
				nrm_data_q <= '0;
			end
		end
	end

	assign nrm_valid = nrm_valid_q;
	assign nrm_data  = nrm_data_q;

endmodule

>>> sv/vna_checker.sv
// Port-level checks for vertex_normal_accumulator, bound to the top level.
// Depends on vna_pkg.
module vna_port_checks import vna_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input in_item_t  cmd_data,
	input logic      nrm_valid,
	input logic      nrm_stall,
	input out_item_t nrm_data
);

	a_beat_held: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_valid && nrm_stall |=> nrm_valid)
		else $error("result beat dropped while stalled");

	a_beat_stable: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_valid && nrm_stall |=> $stable(nrm_data))
		else $error("result payload changed while stalled");

	a_sweep_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> cmd_stall)
		else $error("command taken during reset sweep");

	a_no_result_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !nrm_valid)
		else $error("result out of reset without a command");

endmodule

bind vertex_normal_accumulator vna_port_checks u_vna_port_checks (.*);
